### rtl/core/sobel_edge_detect_3x3_macros.svh
// ----------------------------------------------------------------------------
// Sobel edge detector assertion macros
// Shared concurrent assertion forms for the edge detector modules.
// ----------------------------------------------------------------------------
`ifndef SOBEL_EDGE_DETECT_3X3_MACROS_SVH
`define SOBEL_EDGE_DETECT_3X3_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SED_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sobel edge detector: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SED_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sobel edge detector: next-cycle check failed");

`endif

### rtl/core/sed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel edge detector package
// Shared types and constants for the streaming 3x3 Sobel edge detector.
// ----------------------------------------------------------------------------
package sed_pkg;

    localparam int PIX_W     = 8;
    localparam int ROW_W     = 12;
    localparam int COL_W     = 11;
    localparam int CNT_COL_W = 12;
    localparam int CFG_W     = 13;
    localparam int OUT_TDATA_W = 32;

    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    localparam int DEF_WIDTH  = 640;
    localparam int DEF_HEIGHT = 480;
    localparam int MAX_HEIGHT = 4096;

    typedef logic [PIX_W-1:0] pix_t;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    // One window column: pixels of the rows r-2, r-1 and r.
    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } pix_col_t;

    // Position flags of a pixel, worked out when it is accepted.
    typedef struct packed {
        logic first_row;
        logic row_last;
        logic col_ge1;
        logic col_last;
        logic interior;
    } pos_flags_t;

    // Results caused by one pixel, handed to the output stage.
    // mask[0]: border or interior result, mask[1]: right border of the row
    // above, mask[2]: own border result on the last row.
    typedef struct packed {
        logic [2:0]       mask;
        pix_t             edge0;
        logic [ROW_W-1:0] row0;
        logic [COL_W-1:0] col0;
        logic [ROW_W-1:0] row_up;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } emit_item_t;

endpackage

### rtl/core/sed_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module sed_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/core/sed_win_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel window column cell
// Holds one column of the 3x3 window and passes it to its neighbor on shift.
// ----------------------------------------------------------------------------
module sed_win_cell
    import sed_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     shift_en,
    input  pix_col_t col_in,
    output pix_col_t col_out
);

    pix_col_t col_reg;
    pix_col_t col_next;

    // Take the neighbor's column when the window moves on.
    always_comb begin
        col_next = col_reg;
        if (shift_en) begin
            col_next = col_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
        end else begin
            col_reg <= col_next;
        end
    end

    assign col_out = col_reg;

endmodule

### rtl/core/sed_grad.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel gradient unit
// Computes 255 - min(255, |Gx| + |Gy|) over a 3x3 window.
// ----------------------------------------------------------------------------
module sed_grad
    import sed_pkg::*;
(
    input  pix_col_t left_col,
    input  pix_col_t center_col,
    input  pix_col_t right_col,
    output pix_t     edge_value
);

    logic [9:0]         sum_left;
    logic [9:0]         sum_right;
    logic [9:0]         sum_top;
    logic [9:0]         sum_bot;
    logic signed [10:0] gx;
    logic signed [10:0] gy;
    logic [10:0]        abs_gx;
    logic [10:0]        abs_gy;
    logic [10:0]        mag;

    // Weighted column and row sums with weights 1, 2, 1.
    always_comb begin
        sum_left  = {2'b00, left_col.top} + {1'b0, left_col.mid, 1'b0}
                  + {2'b00, left_col.bot};
        sum_right = {2'b00, right_col.top} + {1'b0, right_col.mid, 1'b0}
                  + {2'b00, right_col.bot};
        sum_top   = {2'b00, left_col.top} + {1'b0, center_col.top, 1'b0}
                  + {2'b00, right_col.top};
        sum_bot   = {2'b00, left_col.bot} + {1'b0, center_col.bot, 1'b0}
                  + {2'b00, right_col.bot};
    end

    // Gradients, magnitudes and the clamped, inverted result.
    always_comb begin
        gx     = $signed({1'b0, sum_right}) - $signed({1'b0, sum_left});
        gy     = $signed({1'b0, sum_bot}) - $signed({1'b0, sum_top});
        abs_gx = gx[10] ? 11'(-gx) : 11'(gx);
        abs_gy = gy[10] ? 11'(-gy) : 11'(gy);
        mag    = abs_gx + abs_gy;
        if (mag > 11'(PIX_MAX)) begin
            edge_value = '0;
        end else begin
            edge_value = PIX_MAX - mag[7:0];
        end
    end

endmodule

### rtl/core/sed_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sobel result emitter
// Output register stage that sends the up to three results of one pixel.
// ----------------------------------------------------------------------------
`include "sobel_edge_detect_3x3_macros.svh"

module sed_emit
    import sed_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   ld_valid,
    output logic                   ld_ready,
    input  emit_item_t             ld_item,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0: edge_value[7:0], out_row[19:8], out_col[30:20], zero.
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    emit_item_t item_reg;
    emit_item_t item_next;
    logic [2:0] mask_reg;
    logic [2:0] mask_next;
    logic [2:0] sel;
    logic [2:0] mask_left;
    logic       pop;
    logic [7:0] out_edge;
    logic [ROW_W-1:0] out_row;
    logic [COL_W-1:0] out_col;
    logic       out_last;

    // Pick the lowest pending result.
    always_comb begin
        sel = 3'b000;
        priority if (mask_reg[0]) begin
            sel = 3'b001;
        end else if (mask_reg[1]) begin
            sel = 3'b010;
        end else if (mask_reg[2]) begin
            sel = 3'b100;
        end
    end

    assign m_tvalid  = |mask_reg;
    assign pop       = m_tvalid && m_tready;
    assign mask_left = pop ? (mask_reg & ~sel) : mask_reg;
    assign ld_ready  = (mask_left == 3'b000);

    // Next pending set and item.
    always_comb begin
        mask_next = mask_left;
        item_next = item_reg;
        if (ld_valid && ld_ready) begin
            mask_next = ld_item.mask;
            item_next = ld_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= '0;
        end else begin
            mask_reg <= mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
    end

    // Output fields of the selected result.
    always_comb begin
        out_edge = PIX_MAX;
        out_row  = item_reg.row;
        out_col  = item_reg.col;
        out_last = 1'b0;
        priority if (sel[0]) begin
            out_edge = item_reg.edge0;
            out_row  = item_reg.row0;
            out_col  = item_reg.col0;
        end else if (sel[1]) begin
            out_row  = item_reg.row_up;
        end else begin
            out_last = item_reg.last;
        end
    end

    assign m_tdata = {1'b0, out_col, out_row, out_edge};
    assign m_tlast = out_last;

    // A loaded item shows exactly its own result set.
    `SED_ASSERT_NEXT(a_load_mask, aclk, aresetn, ld_valid && ld_ready, mask_reg == $past(ld_item.mask))
    // Popping one of several pending results leaves the output valid.
    `SED_ASSERT_NEXT(a_pop_keeps, aclk, aresetn, pop && ($countones(mask_reg) > 1), m_tvalid)
    // The frame end marker only comes on the final result of an item.
    `SED_ASSERT_NOW(a_last_final, aclk, aresetn, m_tvalid && m_tlast, mask_reg == 3'b100)

endmodule

### rtl/core/sobel_edge_detect_3x3.sv
// A pixel passes the pixel stage register and the emitter output register before
// its results go out. Throughput: one pixel per cycle while each pixel causes
// at most one result and m_tready is high; a pixel that causes more results
// keeps the emitter until all are sent, and the input stalls meanwhile.
// Reset (aresetn low, synchronous) sets 640 x 480, clears counters and window.
// Line buffer contents are not cleared; they only feed interior results.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Streaming 3x3 Sobel edge detector
// Two line buffers, a chain of window column cells and a result emitter.
// ----------------------------------------------------------------------------
`include "sobel_edge_detect_3x3_macros.svh"

module sobel_edge_detect_3x3
    import sed_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // Fields from bit 0: gray_pixel[7:0].
    input  logic [7:0]             s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // Fields from bit 0: edge_value[7:0], out_row[19:8], out_col[30:20], zero.
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RESET_W = (DEF_WIDTH > MAX_WIDTH) ? MAX_WIDTH : DEF_WIDTH;
    localparam logic [CNT_COL_W-1:0] RESET_W_LAST = CNT_COL_W'(RESET_W - 1);
    localparam logic [ROW_W-1:0]     RESET_H_LAST = ROW_W'(DEF_HEIGHT - 1);
    localparam logic [13:0]          MAXW14 = 14'(MAX_WIDTH);

    // Sizes, kept as last column and last row index.
    logic [CNT_COL_W-1:0] w_last_reg, w_last_next;
    logic [ROW_W-1:0]     h_last_reg, h_last_next;
    logic [13:0]          cfg_w14;
    logic [13:0]          cfg_h14;

    // Position counters of the next pixel.
    logic [CNT_COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;

    // Stage holding the accepted pixel while its line buffer data is read.
    logic                 s1_valid_reg, s1_valid_next;
    pix_t                 s1_pix_reg;
    logic [ROW_W-1:0]     s1_row_reg;
    logic [CNT_COL_W-1:0] s1_col_reg;
    pos_flags_t           s1_flags_reg;
    pos_flags_t           flags_now;

    logic       accept;
    logic       commit;
    logic       emit_ready;
    pix_t       up_q;
    pix_t       mid_q;
    pix_col_t   col_now;
    pix_col_t   col_d1;
    pix_col_t   col_d2;
    pix_t       grad_value;
    emit_item_t ld_item;

    assign accept   = s_tvalid && s_tready;
    assign commit   = s1_valid_reg && emit_ready;
    assign s_tready = !s1_valid_reg || emit_ready;

    // Clamp written sizes to their working ranges.
    always_comb begin
        cfg_w14 = {2'b00, cfg_wdata[11:0]};
        if (cfg_w14 < 14'd3) begin
            cfg_w14 = 14'd3;
        end else if (cfg_w14 > MAXW14) begin
            cfg_w14 = MAXW14;
        end
        cfg_h14 = {1'b0, cfg_wdata};
        if (cfg_h14 < 14'd3) begin
            cfg_h14 = 14'd3;
        end else if (cfg_h14 > 14'(MAX_HEIGHT)) begin
            cfg_h14 = 14'(MAX_HEIGHT);
        end
    end

    // Size registers and position counters; a size write restarts the frame.
    always_comb begin
        w_last_next = w_last_reg;
        h_last_next = h_last_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        if (accept) begin
            if (col_reg == w_last_reg) begin
                col_next = '0;
                row_next = (row_reg == h_last_reg) ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
        if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_IMAGE_WIDTH: begin
                    w_last_next = CNT_COL_W'(cfg_w14 - 14'd1);
                end
                REG_IMAGE_HEIGHT: begin
                    h_last_next = ROW_W'(cfg_h14 - 14'd1);
                end
                default: begin
                end
            endcase
            col_next = '0;
            row_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg <= RESET_W_LAST;
            h_last_reg <= RESET_H_LAST;
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            w_last_reg <= w_last_next;
            h_last_reg <= h_last_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // Position flags of the pixel being accepted.
    always_comb begin
        flags_now.first_row = (row_reg == '0);
        flags_now.row_last  = (row_reg == h_last_reg);
        flags_now.col_ge1   = (col_reg != '0);
        flags_now.col_last  = (col_reg == w_last_reg);
        flags_now.interior  = (row_reg[ROW_W-1:1] != '0) && (col_reg[CNT_COL_W-1:1] != '0);
    end

    // Pixel stage register.
    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (commit) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg   <= s_tdata;
            s1_row_reg   <= row_reg;
            s1_col_reg   <= col_reg;
            s1_flags_reg <= flags_now;
        end
    end

    // Line buffers: read on accept, shift the column down a row on commit.
    sed_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .aclk    (aclk),
        .wr_en   (commit),
        .wr_addr (AW'(s1_col_reg)),
        .wr_data (mid_q),
        .rd_en   (accept),
        .rd_addr (AW'(col_reg)),
        .rd_data (up_q)
    );

    sed_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_middle (
        .aclk    (aclk),
        .wr_en   (commit),
        .wr_addr (AW'(s1_col_reg)),
        .wr_data (s1_pix_reg),
        .rd_en   (accept),
        .rd_addr (AW'(col_reg)),
        .rd_data (mid_q)
    );

    // Window: the current column feeds a chain of two column cells.
    assign col_now = '{top: up_q, mid: mid_q, bot: s1_pix_reg};

    sed_win_cell u_cell_d1 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (commit),
        .col_in   (col_now),
        .col_out  (col_d1)
    );

    sed_win_cell u_cell_d2 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .shift_en (commit),
        .col_in   (col_d1),
        .col_out  (col_d2)
    );

    sed_grad u_grad (
        .left_col   (col_d2),
        .center_col (col_d1),
        .right_col  (col_now),
        .edge_value (grad_value)
    );

    // Build the result set of the pixel in the stage.
    always_comb begin
        ld_item.mask   = {s1_flags_reg.row_last,
                          !s1_flags_reg.first_row && s1_flags_reg.col_last,
                          s1_flags_reg.first_row || s1_flags_reg.col_ge1};
        ld_item.edge0  = s1_flags_reg.interior ? grad_value : PIX_MAX;
        ld_item.row_up = s1_row_reg - 1'b1;
        ld_item.row0   = s1_flags_reg.first_row ? s1_row_reg : ld_item.row_up;
        ld_item.col    = s1_col_reg[COL_W-1:0];
        ld_item.col0   = s1_flags_reg.first_row ? ld_item.col : ld_item.col - 1'b1;
        ld_item.row    = s1_row_reg;
        ld_item.last   = s1_flags_reg.col_last;
    end

    sed_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ld_valid (s1_valid_reg),
        .ld_ready (emit_ready),
        .ld_item  (ld_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Counters never run past the frame size.
    `SED_ASSERT_NOW(a_col_range, aclk, aresetn, 1'b1, col_reg <= w_last_reg)
    `SED_ASSERT_NOW(a_row_range, aclk, aresetn, 1'b1, row_reg <= h_last_reg)
    // An accepted pixel occupies the pixel stage in the next cycle.
    `SED_ASSERT_NEXT(a_accept_fill, aclk, aresetn, accept, s1_valid_reg)
    // A pixel waiting on the emitter keeps its column, so the RAM data stays.
    `SED_ASSERT_NEXT(a_stall_hold, aclk, aresetn, s1_valid_reg && !emit_ready, s1_valid_reg && $stable(s1_col_reg))

endmodule
